>>> src/chained_hash_table_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the chained hash table unit
// Shared forms for the concurrent checks in the RTL files.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_UNIT_MACROS_SVH
`define CHAINED_HASH_TABLE_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CHT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/cht_pkg.sv
// ---------------------------------------------------------------------------
// cht_pkg
// Types, constants and codes shared by the chained hash table unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cht_pkg;

	localparam int BUCKETS_DEF = 1024;
	localparam int ENTRIES_DEF = 1024;

	localparam logic [34:0] HASH_PRIME   = 35'd32212254719;
	localparam logic [10:0] BCOUNT_RESET = 11'd1000;
	localparam logic [31:0] MUL_RESET    = 32'd1;
	localparam logic [31:0] ADD_RESET    = 32'd0;
	localparam logic [10:0] PROBE_MAX    = 11'd2047;

	localparam logic [1:0] CFG_COEFF_MUL    = 2'd0;
	localparam logic [1:0] CFG_COEFF_ADD    = 2'd1;
	localparam logic [1:0] CFG_BUCKET_COUNT = 2'd2;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_HIT      = 3'd2;
	localparam logic [2:0] ST_MISS     = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic        operation;
		logic [63:0] lookup_key;
		logic [63:0] value_word;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] read_value;
		logic [10:0] probe_count;
	} out_item_t;

	typedef struct packed {
		logic clr_en;
		logic in_load;
		logic mul0;
		logic mul1;
		logic mod_p_init;
		logic mod_n_init;
		logic mod_step;
		logic walk_start;
		logic walk_adv;
		logic mark_found;
		logic finish;
	} cht_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_last;
		logic head_ok;
		logic key_hit;
		logic link_ok;
		logic out_free;
	} cht_sts_t;

endpackage

>>> src/cht_ctrl.sv
// ---------------------------------------------------------------------------
// cht_ctrl
// Sequencer for the hash, bucket read and chain walk of one transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chained_hash_table_unit_macros.svh"

module cht_ctrl
	import cht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  cht_sts_t sts,
	output cht_cmd_t cmd
);

	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001,
		S_IDLE  = 12'b000000000010,
		S_MUL0  = 12'b000000000100,
		S_MUL1  = 12'b000000001000,
		S_MODPI = 12'b000000010000,
		S_MODP  = 12'b000000100000,
		S_MODNI = 12'b000001000000,
		S_MODN  = 12'b000010000000,
		S_HEAD  = 12'b000100000000,
		S_HCHK  = 12'b001000000000,
		S_EWAIT = 12'b010000000000,
		S_ECMP  = 12'b100000000000
	} state_t;

	typedef enum logic [1:0] {
		F_NONE = 2'b01,
		F_FIN  = 2'b10
	} fin_t;

	state_t state_q, state_d;
	fin_t   fin_q, fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			fin_q   <= F_NONE;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
		end
	end

	assign in_stall = (state_q != S_IDLE) || (fin_q == F_FIN);

	always_comb begin
		state_d = state_q;
		fin_d   = fin_q;
		cmd     = '0;
		if (fin_q == F_FIN) begin
			if (sts.out_free) begin
				cmd.finish = 1'b1;
				fin_d      = F_NONE;
			end
		end else begin
			case (state_q)
				S_CLEAR: begin
					cmd.clr_en = 1'b1;
					if (sts.clr_last) state_d = S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd.in_load = 1'b1;
						state_d     = S_MUL0;
					end
				end
				S_MUL0: begin
					cmd.mul0 = 1'b1;
					state_d  = S_MUL1;
				end
				S_MUL1: begin
					cmd.mul1 = 1'b1;
					state_d  = S_MODPI;
				end
				S_MODPI: begin
					cmd.mod_p_init = 1'b1;
					state_d        = S_MODP;
				end
				S_MODP: begin
					cmd.mod_step = 1'b1;
					if (sts.mod_last) state_d = S_MODNI;
				end
				S_MODNI: begin
					cmd.mod_n_init = 1'b1;
					state_d        = S_MODN;
				end
				S_MODN: begin
					cmd.mod_step = 1'b1;
					if (sts.mod_last) state_d = S_HEAD;
				end
				S_HEAD: begin
					state_d = S_HCHK;
				end
				S_HCHK: begin
					if (sts.head_ok) begin
						cmd.walk_start = 1'b1;
						state_d        = S_EWAIT;
					end else begin
						fin_d   = F_FIN;
						state_d = S_IDLE;
					end
				end
				S_EWAIT: begin
					state_d = S_ECMP;
				end
				S_ECMP: begin
					if (sts.key_hit) begin
						cmd.mark_found = 1'b1;
						fin_d          = F_FIN;
						state_d        = S_IDLE;
					end else begin
						cmd.walk_adv = 1'b1;
						if (sts.link_ok) begin
							state_d = S_EWAIT;
						end else begin
							fin_d   = F_FIN;
							state_d = S_IDLE;
						end
					end
				end
				default: begin
					state_d = S_CLEAR;
				end
			endcase
		end
	end

	`CHT_ASSERT_NEXT(a_accept_starts_hash, in_valid && !in_stall, state_q == S_MUL0, "accepted transaction did not start the hash")
	`CHT_ASSERT_NOW(a_finish_needs_room, cmd.finish, sts.out_free, "result written while the output register is occupied")
	`CHT_ASSERT_NEXT(a_hit_ends_walk, state_q == S_ECMP && fin_q == F_NONE && sts.key_hit, fin_q == F_FIN, "key match did not end the chain walk")

endmodule

>>> src/cht_dpath.sv
// ---------------------------------------------------------------------------
// cht_dpath
// Hash arithmetic, remainder unit, bucket and entry memories, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_dpath
	import cht_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  cht_cmd_t    cmd,
	output cht_sts_t    sts
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW = $clog2(ENTRIES + 1);

	logic [31:0] coeff_mul_q, coeff_add_q;
	logic [10:0] bucket_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_mul_q    <= MUL_RESET;
			coeff_add_q    <= ADD_RESET;
			bucket_count_q <= BCOUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COEFF_MUL:    coeff_mul_q    <= cfg_data;
				CFG_COEFF_ADD:    coeff_add_q    <= cfg_data;
				CFG_BUCKET_COUNT: bucket_count_q <= cfg_data[10:0];
				default:          ;
			endcase
		end
	end

	logic        op_q;
	logic [63:0] key_q, val_q;
	logic [63:0] acc_q, dv_q;
	logic [34:0] rem_q, div_q;
	logic [6:0]  cnt_q;
	logic [31:0] mul_src;
	logic [63:0] prod;
	logic [35:0] rem_sh, rem_sub;
	logic [34:0] eff_n;
	logic [28:0] fold_hi;
	logic [63:0] fold_sum;
	logic [34:0] fold_red;

	assign mul_src = cmd.mul1 ? key_q[63:32] : key_q[31:0];
	assign prod    = mul_src * coeff_mul_q;
	assign rem_sh  = {rem_q, dv_q[63]};
	assign rem_sub = rem_sh - {1'b0, div_q};

	// Two to the 35th is congruent to two to the 31st plus one modulo the hash prime.
	assign fold_hi  = acc_q[63:35];
	assign fold_sum = {4'd0, fold_hi, 31'd0} + {35'd0, fold_hi} + {29'd0, acc_q[34:0]};
	assign fold_red = (acc_q[34:0] >= HASH_PRIME) ? acc_q[34:0] - HASH_PRIME : acc_q[34:0];

	always_comb begin
		if (bucket_count_q == 11'd0) begin
			eff_n = 35'd1;
		end else if (35'(bucket_count_q) > 35'(BUCKETS)) begin
			eff_n = 35'(BUCKETS);
		end else begin
			eff_n = 35'(bucket_count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			op_q  <= in_data.operation;
			key_q <= in_data.lookup_key;
			val_q <= in_data.value_word;
		end
		if (cmd.mul0) acc_q <= prod + {32'd0, coeff_add_q};
		if (cmd.mul1) acc_q <= acc_q + {prod[31:0], 32'd0};
		if (cmd.mod_p_init) begin
			cnt_q <= 7'd0;
		end else if (cmd.mod_n_init) begin
			dv_q  <= {rem_q, 29'd0};
			rem_q <= '0;
			div_q <= eff_n;
			cnt_q <= 7'd35;
		end else if (cmd.mod_step) begin
			if (cnt_q == 7'd0) begin
				acc_q <= fold_sum;
				rem_q <= fold_red;
			end else begin
				dv_q  <= {dv_q[62:0], 1'b0};
				rem_q <= rem_sub[35] ? rem_sh[34:0] : rem_sub[34:0];
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	logic [BW-1:0] bucket;
	assign bucket = rem_q[BW-1:0];

	logic [EW:0]   head_mem [BUCKETS];
	logic [63:0]   key_mem  [ENTRIES];
	logic [63:0]   val_mem  [ENTRIES];
	logic [EW:0]   link_mem [ENTRIES];
	logic [EW:0]   head_rd_q, link_rd_q;
	logic [63:0]   key_rd_q, val_rd_q;
	logic [EW-1:0] cur_q;
	logic [BW-1:0] clr_cnt_q;
	logic [UW-1:0] used_q;
	logic [10:0]   probes_q;
	logic          found_q;
	logic          pool_full, do_insert, do_update;
	logic [EW-1:0] new_idx;

	assign pool_full = used_q >= UW'(ENTRIES);
	assign new_idx   = used_q[EW-1:0];
	assign do_update = cmd.finish && op_q == OP_INSERT && found_q;
	assign do_insert = cmd.finish && op_q == OP_INSERT && !found_q && !pool_full;

	always_ff @(posedge clk) begin
		head_rd_q <= head_mem[bucket];
		key_rd_q  <= key_mem[cur_q];
		val_rd_q  <= val_mem[cur_q];
		link_rd_q <= link_mem[cur_q];
		if (cmd.clr_en) begin
			head_mem[clr_cnt_q] <= '0;
		end else if (do_insert) begin
			head_mem[bucket] <= {1'b1, new_idx};
		end
		if (do_insert) begin
			key_mem[new_idx]  <= key_q;
			link_mem[new_idx] <= head_rd_q;
		end
		if (do_insert || do_update) begin
			val_mem[do_insert ? new_idx : cur_q] <= val_q;
		end
		if (cmd.walk_start) cur_q <= head_rd_q[EW-1:0];
		if (cmd.walk_adv)   cur_q <= link_rd_q[EW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			used_q    <= '0;
			probes_q  <= '0;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clr_en) clr_cnt_q <= clr_cnt_q + BW'(1);
			if (cmd.in_load) begin
				probes_q <= '0;
				found_q  <= 1'b0;
			end
			if (cmd.mark_found) found_q <= 1'b1;
			if (cmd.walk_adv && probes_q != PROBE_MAX) probes_q <= probes_q + 11'd1;
			if (do_insert) used_q <= used_q + UW'(1);
			if (cmd.finish) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data.read_value  <= (op_q == OP_LOOKUP && found_q) ? val_rd_q : 64'd0;
			out_data.probe_count <= (do_insert && probes_q != PROBE_MAX) ?
				probes_q + 11'd1 : probes_q;
			if (op_q == OP_LOOKUP) begin
				if (found_q) begin
					out_data.status <= ST_HIT;
				end else begin
					out_data.status <= ST_MISS;
				end
			end else if (found_q) begin
				out_data.status <= ST_UPDATED;
			end else if (pool_full) begin
				out_data.status <= ST_FULL;
			end else begin
				out_data.status <= ST_INSERTED;
			end
		end
	end

	assign sts.clr_last = clr_cnt_q == BW'(BUCKETS - 1);
	assign sts.mod_last = (cnt_q == 7'd0) ? (fold_hi == '0) : (cnt_q == 7'd1);
	assign sts.head_ok  = head_rd_q[EW];
	assign sts.key_hit  = key_rd_q == key_q;
	assign sts.link_ok  = link_rd_q[EW];
	assign sts.out_free = !out_valid || !out_stall;

endmodule

>>> src/chained_hash_table_unit.sv
// ---------------------------------------------------------------------------
// chained_hash_table_unit
// Key-value table with chained buckets and a universal hash.
// ---------------------------------------------------------------------------
// One transaction at a time. A transaction runs the hash multiply, folds the
// hash down modulo the hash prime, forms the bucket remainder bit-serially
// and reads the bucket head, then examines each chain entry in turn and posts
// the result once the result register is free. Its length is set mostly by
// the one-bit-per-cycle bucket remainder and the registered entry memory
// reads. After reset the bucket table is cleared, during which no transaction
// is accepted; configuration writes are taken throughout. The result register
// lets the next transaction start while a result waits.
`timescale 1ns / 1ps

module chained_hash_table_unit
	import cht_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	cht_cmd_t cmd;
	cht_sts_t sts;

	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cht_dpath #(
		.BUCKETS (BUCKETS),
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chained hash table unit. A table of directed
// lookups and inserts runs first on the reset settings. Randomized phases
// follow under several hash and bucket settings, down to a single bucket,
// until the entry pool runs full. Each result is compared with the value that
// its directed row gives, or else with a software copy of the table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import cht_pkg::*;

	localparam int NENT = 1024;
	localparam int NBKT = 1024;

	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;

	chained_hash_table_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Software copy of the table.
	bit [31:0] hash_mul;
	bit [31:0] hash_add;
	bit [10:0] bucket_reg;
	bit [10:0] head_idx [NBKT];
	bit        head_ok [NBKT];
	bit [63:0] slot_key [NENT];
	bit [63:0] slot_val [NENT];
	bit [10:0] slot_link [NENT];
	bit        slot_link_ok [NENT];
	int        slots_used;

	out_item_t pending_results[$];
	bit [63:0] stored_keys[$];
	dir_row_t  dir_rows[$];
	int        mismatch_count;
	int        sent_count;
	int        taken_count;

	function automatic out_item_t lookup_or_store(in_item_t req);
		bit [63:0] h;
		int        n, b, cur, walked, probes;
		bit        ok, found;
		out_item_t res;
		h = req.lookup_key * {32'b0, hash_mul} + {32'b0, hash_add};
		h = h % {29'b0, HASH_PRIME};
		n = (bucket_reg == 0) ? 1 : ((bucket_reg > NBKT) ? NBKT : bucket_reg);
		b = int'(h % n);
		ok = head_ok[b];
		cur = ok ? head_idx[b] : 0;
		found = 0;
		walked = 0;
		probes = 0;
		res = '0;
		while (ok && walked < NENT) begin
			if (slot_key[cur] == req.lookup_key) begin
				found = 1;
				break;
			end
			probes++;
			walked++;
			ok = slot_link_ok[cur];
			cur = slot_link[cur];
		end
		if (req.operation == OP_LOOKUP) begin
			res.status = found ? ST_HIT : ST_MISS;
			if (found)
				res.read_value = slot_val[cur];
		end else if (found) begin
			slot_val[cur] = req.value_word;
			res.status = ST_UPDATED;
		end else if (slots_used >= NENT) begin
			res.status = ST_FULL;
		end else begin
			slot_key[slots_used] = req.lookup_key;
			slot_val[slots_used] = req.value_word;
			slot_link[slots_used] = head_idx[b];
			slot_link_ok[slots_used] = head_ok[b];
			head_idx[b] = 11'(slots_used);
			head_ok[b] = 1;
			slots_used++;
			probes++;
			res.status = ST_INSERTED;
		end
		res.probe_count = (probes > PROBE_MAX) ? PROBE_MAX : 11'(probes);
		return res;
	endfunction

	function automatic int pick_wait(int count);
		if (count % 150 < 25)
			return 0;
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("Test completed with failures");
		$finish;
	end

	task automatic add_row(bit op, bit [63:0] k, bit [63:0] v, bit typed,
			bit [2:0] st, bit [63:0] rv, bit [10:0] pc);
		dir_row_t r;
		r.req = '{operation: op, lookup_key: k, value_word: v};
		r.typed = typed;
		r.want = '{status: st, read_value: rv, probe_count: pc};
		dir_rows.push_back(r);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_COEFF_MUL)
			hash_mul = val;
		else if (idx == CFG_COEFF_ADD)
			hash_add = val;
		else if (idx == CFG_BUCKET_COUNT)
			bucket_reg = val[10:0];
	endtask

	task automatic settle();
		in_valid <= 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic send(in_item_t req, bit typed, out_item_t want);
		int w;
		out_item_t got;
		w = pick_wait(sent_count);
		if (w > 0) begin
			in_valid <= 0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= req;
		do
			@(posedge clk);
		while (in_stall);
		sent_count++;
		got = lookup_or_store(req);
		if (req.operation == OP_INSERT)
			stored_keys.push_back(req.lookup_key);
		pending_results.push_back(typed ? want : got);
	endtask

	task automatic send_random(int ins_pct, int known_pct);
		in_item_t req;
		int sel;
		req.operation = ($urandom_range(1, 100) <= ins_pct) ? OP_INSERT : OP_LOOKUP;
		sel = $urandom_range(0, 15);
		if (stored_keys.size() != 0 && $urandom_range(1, 100) <= known_pct)
			req.lookup_key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
		else if (sel == 0)
			req.lookup_key = '0;
		else if (sel == 1)
			req.lookup_key = '1;
		else
			req.lookup_key = {$urandom, $urandom};
		sel = $urandom_range(0, 15);
		req.value_word = (sel == 0) ? '0 : ((sel == 1) ? '1 : {$urandom, $urandom});
		send(req, 0, '0);
	endtask

	task automatic random_phase(bit [31:0] mul, bit [31:0] add, bit [10:0] bkt,
			int count, int ins_pct, int known_pct);
		write_reg(CFG_COEFF_MUL, mul);
		write_reg(CFG_COEFF_ADD, add);
		write_reg(CFG_BUCKET_COUNT, {21'b0, bkt});
		repeat (count) send_random(ins_pct, known_pct);
		settle();
	endtask

	initial begin
		int extra;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		in_data = '0;
		hash_mul = MUL_RESET;
		hash_add = ADD_RESET;
		bucket_reg = BCOUNT_RESET;
		slots_used = 0;
		mismatch_count = 0;
		sent_count = 0;
		taken_count = 0;
		foreach (head_ok[i]) begin
			head_ok[i] = 0;
			head_idx[i] = '0;
		end
		foreach (slot_key[i]) begin
			slot_key[i] = '0;
			slot_val[i] = '0;
			slot_link[i] = '0;
			slot_link_ok[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1;

		add_row(OP_LOOKUP, 64'd0, 64'd0, 1, ST_MISS, 64'd0, 11'd0);
		add_row(OP_INSERT, 64'd0, '1, 1, ST_INSERTED, 64'd0, 11'd1);
		add_row(OP_LOOKUP, 64'd0, 64'd7, 1, ST_HIT, '1, 11'd0);
		add_row(OP_INSERT, 64'd0, 64'd0, 1, ST_UPDATED, 64'd0, 11'd0);
		add_row(OP_LOOKUP, 64'd0, '1, 1, ST_HIT, 64'd0, 11'd0);
		add_row(OP_INSERT, '1, {32{2'b01}}, 0, '0, '0, '0);
		add_row(OP_LOOKUP, '1, 64'd0, 0, '0, '0, '0);
		add_row(OP_INSERT, 64'd1000, {32{2'b10}}, 1, ST_INSERTED, 64'd0, 11'd2);
		add_row(OP_LOOKUP, 64'd0, 64'd0, 1, ST_HIT, 64'd0, 11'd1);
		add_row(OP_LOOKUP, 64'd2000, 64'd0, 1, ST_MISS, 64'd0, 11'd2);
		add_row(OP_INSERT, 64'd32212254719, 64'd3, 1, ST_INSERTED, 64'd0, 11'd3);
		add_row(OP_INSERT, 64'd1000, '1, 1, ST_UPDATED, 64'd0, 11'd1);
		add_row(OP_LOOKUP, 64'd1000, 64'd0, 1, ST_HIT, '1, 11'd1);
		add_row(OP_INSERT, 64'h8000_0000_0000_0000, 64'd1, 0, '0, '0, '0);
		add_row(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'd0, 0, '0, '0, '0);
		add_row(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 0, '0, '0, '0);

		foreach (dir_rows[i])
			send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		settle();

		// Zero multiplier and zero bucket count put every key in one chain.
		random_phase(32'd0, '1, 11'd0, 40, 70, 40);
		random_phase('1, $urandom, 11'd1024, 100, 80, 20);
		random_phase($urandom, $urandom, 11'd2047, 100, 80, 20);
		random_phase($urandom | 32'd1, 32'd0, 11'd1, 40, 50, 50);

		// Fill the pool, then keep going to see dropped inserts.
		write_reg(CFG_COEFF_MUL, $urandom);
		write_reg(CFG_COEFF_ADD, $urandom);
		write_reg(CFG_BUCKET_COUNT, $urandom_range(1, 1024));
		extra = 0;
		while (extra < 30) begin
			send_random(100, 0);
			if (slots_used >= NENT)
				extra++;
		end
		settle();
		repeat (300) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		int w;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			w = pick_wait(taken_count + 70);
			out_stall <= (w != 0);
			if (w > 0) begin
				repeat (w) @(posedge clk);
				out_stall <= 0;
			end
			do
				@(posedge clk);
			while (!out_valid || out_stall);
			taken_count++;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected transaction result: %p", out_data);
			end else begin
				want = pending_results.pop_front();
				if (out_data.status !== want.status
						|| out_data.read_value !== want.read_value
						|| out_data.probe_count !== want.probe_count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected status %0d value %h probes %0d, got status %0d value %h probes %0d",
							want.status, want.read_value, want.probe_count,
							out_data.status, out_data.read_value, out_data.probe_count);
				end
			end
		end
	end

endmodule
